@@ sv/ece_pkg.sv @@
// Shared types, constants and helpers for the epsilon closure engine.
`timescale 1ns / 1ps

package ece_pkg;

  localparam int unsigned NSTATE  = 16;
  localparam int unsigned SIDX_W  = 4;   // state index width
  localparam int unsigned CNT_W   = 5;   // counter width, holds NSTATE itself
  localparam int unsigned MASK_W  = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_INIT,
    ST_PIVOT_RD,
    ST_SWEEP,
    ST_EMIT,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    seq_state_t         st;
    logic [CNT_W-1:0]   idx;
    logic [CNT_W-1:0]   k;
    logic               busy;
  } seq_ctrl_t;

  function automatic logic [MASK_W-1:0] row_bit(input logic [SIDX_W-1:0] i);
    row_bit = MASK_W'(1) << i;
  endfunction

  // low n bits set, n in 0..NSTATE
  function automatic logic [MASK_W-1:0] col_mask(input logic [CNT_W-1:0] n);
    logic [MASK_W:0] t;
    t = ((MASK_W + 1)'(1) << n) - (MASK_W + 1)'(1);
    col_mask = t[MASK_W-1:0];
  endfunction

endpackage

@@ sv/ece_edge_store.sv @@
// Edge matrix memory with per-row valid bits and a bit-set write.
`timescale 1ns / 1ps

module ece_edge_store
  import ece_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SIDX_W-1:0] rd_addr,
  input  logic              set_en,
  input  logic [SIDX_W-1:0] set_addr,
  input  logic [SIDX_W-1:0] set_col,
  input  logic              clr,
  output logic [MASK_W-1:0] rdata
);

  logic [MASK_W-1:0] mem [NSTATE];
  logic [NSTATE-1:0] valid;
  logic [MASK_W-1:0] rd_q;
  logic              rd_valid;

  // rows never set since the last clear read as zero
  assign rdata = rd_q & {MASK_W{rd_valid}};

  always_ff @(posedge clk) begin
    if (set_en) begin
      mem[set_addr] <= rdata | row_bit(set_col);
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (set_en) begin
        valid[set_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

@@ sv/ece_reach_ram.sv @@
// Working closure rows: 16 x 16 synchronous RAM, one write and one read port.
`timescale 1ns / 1ps

module ece_reach_ram
  import ece_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [SIDX_W-1:0] waddr,
  input  logic [MASK_W-1:0] wdata,
  input  logic [SIDX_W-1:0] raddr,
  output logic [MASK_W-1:0] rdata
);

  logic [MASK_W-1:0] mem [NSTATE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/ece_seq.sv @@
// Sequencer: edge load, closure sweeps, row output and matrix clear.
`timescale 1ns / 1ps

module ece_seq
  import ece_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             edge_present,
  input  logic             last_edge,
  input  logic [CNT_W-1:0] n,
  output seq_ctrl_t        ctrl
);

  seq_state_t       st, st_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] k, k_next;
  logic             last_q;
  logic             busy;
  logic             sweep_end;

  assign sweep_end = (idx == n);

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: begin
        if (start) begin
          if (edge_present) begin
            st_next = ST_EDGE_WR;
          end else if (last_edge) begin
            st_next = ST_INIT;
          end
        end
      end
      ST_EDGE_WR:  st_next = last_q ? ST_INIT : ST_IDLE;
      ST_INIT: begin
        if (n == '0) begin
          st_next = ST_FINISH;
        end else if (sweep_end) begin
          st_next = ST_PIVOT_RD;
        end
      end
      ST_PIVOT_RD: st_next = ST_SWEEP;
      ST_SWEEP: begin
        if (sweep_end) begin
          st_next = (k + CNT_W'(1) == n) ? ST_EMIT : ST_PIVOT_RD;
        end
      end
      ST_EMIT:     st_next = sweep_end ? ST_FINISH : ST_EMIT;
      ST_FINISH:   st_next = ST_IDLE;
      default:     st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = (st != ST_IDLE);
    idx_next = idx;
    k_next   = k;
    if (st_next != st) begin
      idx_next = '0;
    end else if (st == ST_INIT || st == ST_SWEEP || st == ST_EMIT) begin
      idx_next = idx + CNT_W'(1);
    end
    if (st == ST_INIT) begin
      k_next = '0;
    end else if (st == ST_SWEEP && sweep_end) begin
      k_next = k + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= ST_IDLE;
      idx    <= '0;
      k      <= '0;
      last_q <= 1'b0;
    end else begin
      st  <= st_next;
      idx <= idx_next;
      k   <= k_next;
      if (st == ST_IDLE && start) begin
        last_q <= last_edge;
      end
    end
  end

  assign ctrl = '{st: st, idx: idx, k: k, busy: busy};

endmodule

@@ sv/epsilon_closure_engine.sv @@
// Top level of the epsilon closure engine.
`timescale 1ns / 1ps

// Edges are loaded one per transfer; an item carrying an edge keeps busy high while
// its row is read and written back, so the next edge waits until busy falls.
// The item with last_edge set starts the run (after its edge write if it also carries
// an edge): the closure rows are seeded, then n Warshall sweeps run over the row RAM
// (pivot row fetch plus one row read-modify-write per cycle), the rows are read out
// and the edge matrix is cleared; with zero states the run goes straight to the clear.
// Results come out one per cycle in state order on result_valid and cannot be held off.
module epsilon_closure_engine
  import ece_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic [SIDX_W-1:0] from_state,
  input  logic [SIDX_W-1:0] to_state,
  input  logic              edge_present,
  input  logic              last_edge,
  output logic              result_valid,
  output logic [SIDX_W-1:0] row_state,
  output logic [MASK_W-1:0] closure_mask,
  output logic              last_row
);

  logic [CNT_W-1:0]  num_states;
  logic [CNT_W-1:0]  n;
  logic [MASK_W-1:0] cols;
  seq_ctrl_t         ctrl;

  logic [SIDX_W-1:0] from_q, to_q;
  logic [SIDX_W-1:0] edge_raddr;
  logic [MASK_W-1:0] edge_rdata;

  logic              reach_we;
  logic [SIDX_W-1:0] reach_waddr, reach_raddr;
  logic [MASK_W-1:0] reach_wdata, reach_rdata;
  logic [MASK_W-1:0] pivot;
  logic [CNT_W-1:0]  prev_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= CNT_W'(NSTATE);
    end else if (cfg_we) begin
      num_states <= cfg_data;
    end
  end

  assign n    = (num_states > CNT_W'(NSTATE)) ? CNT_W'(NSTATE) : num_states;
  assign cols = col_mask(n);

  ece_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .edge_present (edge_present),
    .last_edge    (last_edge),
    .n            (n),
    .ctrl         (ctrl)
  );

  assign busy = ctrl.busy;

  always_ff @(posedge clk) begin
    if (ctrl.st == ST_IDLE && start) begin
      from_q <= from_state;
      to_q   <= to_state;
    end
  end

  assign edge_raddr = (ctrl.st == ST_IDLE) ? from_state : ctrl.idx[SIDX_W-1:0];

  ece_edge_store u_edge (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (edge_raddr),
    .set_en   (ctrl.st == ST_EDGE_WR),
    .set_addr (from_q),
    .set_col  (to_q),
    .clr      (ctrl.st == ST_FINISH),
    .rdata    (edge_rdata)
  );

  // each row is written the cycle after its read; the pivot row is fetched
  // only after the previous sweep's last write has landed
  assign prev_idx    = ctrl.idx - CNT_W'(1);
  assign reach_waddr = prev_idx[SIDX_W-1:0];
  assign reach_raddr = (ctrl.st == ST_PIVOT_RD) ? ctrl.k[SIDX_W-1:0]
                                                : ctrl.idx[SIDX_W-1:0];
  assign reach_we    = (ctrl.st == ST_INIT || ctrl.st == ST_SWEEP) &&
                       (ctrl.idx != '0);

  always_comb begin
    if (ctrl.st == ST_INIT) begin
      reach_wdata = row_bit(reach_waddr) | (edge_rdata & cols);
    end else begin
      reach_wdata = reach_rdata |
                    (reach_rdata[ctrl.k[SIDX_W-1:0]] ? pivot : '0);
    end
  end

  ece_reach_ram u_reach (
    .clk   (clk),
    .we    (reach_we),
    .waddr (reach_waddr),
    .wdata (reach_wdata),
    .raddr (reach_raddr),
    .rdata (reach_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctrl.st == ST_SWEEP && ctrl.idx == '0) begin
      pivot <= reach_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (ctrl.st == ST_EMIT) && (ctrl.idx != '0);
    end
  end

  always_ff @(posedge clk) begin
    row_state    <= prev_idx[SIDX_W-1:0];
    closure_mask <= reach_rdata;
    last_row     <= (ctrl.idx == n);
  end

  a_result_in_run : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result transfer outside a run");

  a_last_ends : assert property (@(posedge clk) disable iff (rst)
    result_valid && last_row |=> !result_valid)
    else $error("result transfer after final row");

  a_reflexive : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> closure_mask[row_state])
    else $error("closure row misses its own state");

  a_order : assert property (@(posedge clk) disable iff (rst)
    result_valid && $past(result_valid) |-> row_state == $past(row_state) + SIDX_W'(1))
    else $error("rows out of order");

endmodule

@@ tb/tb_epsilon_closure_engine.sv @@
// Testbench for epsilon_closure_engine: directed and random edge sets checked against a predictor.
`timescale 1ns / 1ps

module tb_epsilon_closure_engine;
  import ece_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RAND_ITEMS  = 300;
  localparam int N_DIR       = 19;

  typedef struct packed {
    logic [SIDX_W-1:0] row;
    logic [MASK_W-1:0] mask;
    logic              last;
  } closure_row_t;

  // typed: expected rows are given here; mask 0 means no rows, else one row 0
  typedef struct packed {
    logic              cfg_wr;
    logic [CNT_W-1:0]  cfg_val;
    logic [SIDX_W-1:0] src;
    logic [SIDX_W-1:0] dst;
    logic              present;
    logic              last;
    logic              typed;
    logic [MASK_W-1:0] typed_mask;
  } dir_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CNT_W-1:0]  cfg_data = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [SIDX_W-1:0] from_state = '0;
  logic [SIDX_W-1:0] to_state = '0;
  logic              edge_present = 1'b0;
  logic              last_edge = 1'b0;
  logic              result_valid;
  logic [SIDX_W-1:0] row_state;
  logic [MASK_W-1:0] closure_mask;
  logic              last_row;

  epsilon_closure_engine dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .from_state   (from_state),
    .to_state     (to_state),
    .edge_present (edge_present),
    .last_edge    (last_edge),
    .result_valid (result_valid),
    .row_state    (row_state),
    .closure_mask (closure_mask),
    .last_row     (last_row)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [MASK_W-1:0] edge_rows [NSTATE];
  logic [CNT_W-1:0]  state_count = CNT_W'(16);
  closure_row_t      closure_q [$];
  int                fail_cnt = 0;
  int                quiet_cycles = 0;
  bit                gaps_on = 1'b1;

  initial begin
    foreach (edge_rows[i]) edge_rows[i] = '0;
  end

  function automatic void predict_closure(input logic [SIDX_W-1:0] src, input logic [SIDX_W-1:0] dst,
                                          input logic has_edge, input logic is_last,
                                          input bit push_rows);
    logic [MASK_W-1:0] cols;
    logic [MASK_W-1:0] acc;
    logic [MASK_W-1:0] reach [NSTATE];
    int                n;
    closure_row_t      r;
    if (has_edge) edge_rows[src][dst] = 1'b1;
    if (!is_last) return;
    n = (state_count > NSTATE) ? NSTATE : int'(state_count);
    cols = (n >= MASK_W) ? '1 : MASK_W'((1 << n) - 1);
    for (int i = 0; i < n; i++) reach[i] = (MASK_W'(1) << i) | (edge_rows[i] & cols);
    // n passes is enough for any path length
    for (int p = 0; p < n; p++) begin
      for (int i = 0; i < n; i++) begin
        acc = reach[i];
        for (int j = 0; j < n; j++)
          if (acc[j]) acc |= edge_rows[j] & cols;
        reach[i] = acc;
      end
    end
    if (push_rows) begin
      for (int i = 0; i < n; i++) begin
        r.row  = SIDX_W'(i);
        r.mask = reach[i];
        r.last = (i == n - 1);
        closure_q.push_back(r);
      end
    end
    foreach (edge_rows[i]) edge_rows[i] = '0;
  endfunction

  // called at a rising edge; returns at the edge where the transfer happens
  task automatic send_item(input logic [SIDX_W-1:0] src, input logic [SIDX_W-1:0] dst,
                           input logic has_edge, input logic is_last, input bit push_rows);
    while (gaps_on && $urandom_range(0, 99) < 31) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    from_state   <= src;
    to_state     <= dst;
    edge_present <= has_edge;
    last_edge    <= is_last;
    do @(negedge clk); while (busy);
    @(posedge clk);
    predict_closure(src, dst, has_edge, is_last, push_rows);
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(negedge clk); while (closure_q.size() != 0 || busy);
    // extra idle margin after the last run ends
    repeat (8) @(posedge clk);
  endtask

  task automatic write_num_states(input logic [CNT_W-1:0] val);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we      <= 1'b0;
    state_count = val;
  endtask

  // result check and watchdog
  always @(negedge clk) begin
    closure_row_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((start && !busy) || result_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (result_valid) begin
        if (closure_q.size() == 0) begin
          $error("result with nothing expected: row_state %0d closure_mask %h",
                 row_state, closure_mask);
          fail_cnt++;
        end else begin
          want = closure_q.pop_front();
          if (row_state !== want.row) begin
            $error("row_state: expected %0d, got %0d", want.row, row_state);
            fail_cnt++;
          end
          if (closure_mask !== want.mask) begin
            $error("closure_mask: expected %h, got %h", want.mask, closure_mask);
            fail_cnt++;
          end
          if (last_row !== want.last) begin
            $error("last_row: expected %0d, got %0d", want.last, last_row);
            fail_cnt++;
          end
        end
      end
    end
  end

  initial begin
    dir_item_t    dir_tab [N_DIR];
    closure_row_t typed_row;
    int           items_sent;
    int           n_eff;
    int           k;
    int           pick;
    logic [SIDX_W-1:0] s, d;

    dir_tab = '{
      // bare marker right after reset: identity rows over 16 states
      '{1'b0, 5'd0,  4'd0,  4'd0,  1'b0, 1'b1, 1'b0, 16'h0000},
      '{1'b0, 5'd0,  4'd0,  4'd15, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 5'd0,  4'd15, 4'd0,  1'b1, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 5'd0,  4'd15, 4'd15, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 5'd0,  4'd3,  4'd7,  1'b1, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 5'd0,  4'd7,  4'd3,  1'b1, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 5'd0,  4'd5,  4'd6,  1'b1, 1'b1, 1'b0, 16'h0000},
      // one state: edges beyond it take no part
      '{1'b1, 5'd1,  4'd0,  4'd0,  1'b1, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 5'd0,  4'd0,  4'd5,  1'b1, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 5'd0,  4'd9,  4'd0,  1'b1, 1'b1, 1'b1, 16'h0001},
      // zero states: no rows
      '{1'b1, 5'd0,  4'd2,  4'd3,  1'b1, 1'b1, 1'b1, 16'h0000},
      // oversized counts clamp to 16
      '{1'b1, 5'd31, 4'd14, 4'd15, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 5'd0,  4'd1,  4'd14, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 5'd0,  4'd0,  4'd1,  1'b1, 1'b1, 1'b0, 16'h0000},
      // bare marker with endpoint fields set must not add an edge
      '{1'b1, 5'd17, 4'd15, 4'd15, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{1'b1, 5'd2,  4'd1,  4'd0,  1'b1, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 5'd0,  4'd0,  4'd1,  1'b1, 1'b1, 1'b0, 16'h0000},
      '{1'b1, 5'd16, 4'd15, 4'd0,  1'b1, 1'b1, 1'b0, 16'h0000},
      '{1'b1, 5'd1,  4'd0,  4'd0,  1'b0, 1'b1, 1'b1, 16'h0001}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_wr) write_num_states(dir_tab[i].cfg_val);
      send_item(dir_tab[i].src, dir_tab[i].dst, dir_tab[i].present, dir_tab[i].last,
                !dir_tab[i].typed);
      if (dir_tab[i].typed && dir_tab[i].typed_mask != '0) begin
        typed_row.row  = '0;
        typed_row.mask = dir_tab[i].typed_mask;
        typed_row.last = 1'b1;
        closure_q.push_back(typed_row);
      end
    end

    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 10)      write_num_states('0);
        else if (pick < 30) write_num_states(CNT_W'($urandom_range(17, 31)));
        else                write_num_states(CNT_W'($urandom_range(1, 16)));
      end
      n_eff = (state_count > NSTATE) ? NSTATE : int'(state_count);
      k = $urandom_range(0, 5);
      for (int e = 0; e <= k; e++) begin
        gaps_on = !(items_sent >= 120 && items_sent < 190);
        pick = $urandom_range(0, 99);
        if (pick < 20 || n_eff == 0) begin
          s = SIDX_W'($urandom_range(0, 15));
          d = SIDX_W'($urandom_range(0, 15));
        end else begin
          s = SIDX_W'($urandom_range(0, n_eff - 1));
          d = SIDX_W'($urandom_range(0, n_eff - 1));
        end
        if (e == k) begin
          send_item(s, d, logic'($urandom_range(0, 1)), 1'b1, 1'b1);
          items_sent++;
        end else if (pick >= 90) begin
          // bare marker that does not end the set
          send_item(s, d, 1'b0, 1'b0, 1'b1);
          items_sent++;
        end else begin
          send_item(s, d, 1'b1, 1'b0, 1'b1);
          items_sent++;
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ece_pkg.sv
sv/ece_edge_store.sv
sv/ece_reach_ram.sv
sv/ece_seq.sv
sv/epsilon_closure_engine.sv
tb/tb_epsilon_closure_engine.sv
